// ----- src/ppdc_pkg.sv -----
// ----------------------------------------------------------------------------
// ppdc_pkg: shared widths and codes of the PID position/delta controller
// Field widths that do not vary, register indexes and operation codes.
// ----------------------------------------------------------------------------
package ppdc_pkg;

  // Fixed field widths.
  localparam int GAIN_W      = 24;
  localparam int LIMIT_W     = 15;
  localparam int ERR_LIMIT_W = 16;
  localparam int DRIVE_W     = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 24;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_CONTROL_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_LIMIT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_LIMIT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P         = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I         = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D         = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ERROR_LIMIT    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_ZONE      = 3'd7;

  // Operation codes carried in tuser.
  localparam logic OP_NORMAL = 1'b0;
  localparam logic OP_GYRO   = 1'b1;

  // Controller modes.
  localparam logic MODE_POSITIONAL  = 1'b0;
  localparam logic MODE_INCREMENTAL = 1'b1;

  // Divisor of the gyro derivative term.
  localparam logic [7:0] GYRO_DIV = 8'd100;

endpackage

// ----- src/pid_position_delta_controller_core.sv -----
// ----------------------------------------------------------------------------
// pid_position_delta_controller_core: positional / incremental PID controller
// Paths: a positional normal item runs the three products and the derivative
//   filter, a positional gyro item the divide-by-100 loop instead of the filter,
//   an incremental normal item the products only; the rest skip the products.
// Flow: one item at a time through the shared multiplier and the radix-16
//   divide-by-100 loop. A new item is taken while a result waits.
// Reset: synchronous, active low; resets configuration and sequencer, clears history and accumulators.
// ----------------------------------------------------------------------------
module pid_position_delta_controller_core #(
  parameter int SAMPLE_WIDTH  = 16,
  parameter int FRACTION_BITS = 16
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  // Configuration write port.
  input  logic                                      cfg_wr_en,
  input  logic [ppdc_pkg::CFG_IDX_W-1:0]            cfg_index,
  input  logic [ppdc_pkg::CFG_DATA_W-1:0]           cfg_data,
  // Input items. tdata: measured, target, gyro_rate. tuser: operation.
  input  logic                                      in_tvalid,
  output logic                                      in_tready,
  input  logic [((3*SAMPLE_WIDTH+7)/8)*8-1:0]       in_tdata,
  input  logic                                      in_tuser,
  // Result items. tdata: drive. tuser: suppressed.
  output logic                                      out_tvalid,
  input  logic                                      out_tready,
  output logic [ppdc_pkg::DRIVE_W-1:0]              out_tdata,
  output logic                                      out_tuser
);
  import ppdc_pkg::*;

  localparam int SW = SAMPLE_WIDTH;
  localparam int F  = FRACTION_BITS;
  // Error and multiplier operand widths.
  localparam int EW = SW + 1;
  localparam int AW = GAIN_W + 1;
  localparam int BW = SW + 3;
  localparam int PW = AW + BW;
  // Filtered derivative, integral / output and sum widths.
  localparam int DW   = GAIN_W + SW + 2;
  localparam int IW   = LIMIT_W + F + 1;
  localparam int SUMW = ((PW > IW) ? PW : IW) + 3;
  // Filter chunking: difference split into CW-bit chunks, top chunk signed.
  localparam int CW     = BW - 1;
  localparam int NCHUNK = (DW + 1 + CW - 1) / CW;
  localparam int DIFFW  = NCHUNK * CW;
  localparam int ACCW   = DW + F + 3;
  // Divide-by-100 loop: four quotient bits per cycle.
  localparam int DIVW      = ((PW + 3) / 4) * 4;
  localparam int DIV_STEPS = DIVW / 4;
  localparam int CNT_MAX   = (NCHUNK > DIV_STEPS) ? NCHUNK : DIV_STEPS;
  localparam int CNTW      = $clog2(CNT_MAX + 1);
  localparam int CMPW      = (EW > ERR_LIMIT_W) ? EW : ERR_LIMIT_W;
  // Fixed-point constants.
  localparam int LPF_NEW = ((3 << F) + 2) / 5;
  localparam int KI_MIN  = ((1 << F) + 999) / 1000;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_MUL_P, S_MUL_I, S_MUL_D, S_DIFF, S_LPF, S_FILT,
    S_DIV_LOAD, S_DIV, S_DIV_END, S_SUM, S_OUT
  } state_t;

  // Symmetric clamp to +/- lim in Q.F.
  function automatic logic signed [IW-1:0] clamp_q(input logic signed [SUMW-1:0] x,
                                                   input logic [LIMIT_W-1:0] lim);
    logic signed [SUMW-1:0] lim_q;
    lim_q = $signed({{(SUMW-LIMIT_W-F){1'b0}}, lim, {F{1'b0}}});
    if (x > lim_q) begin
      clamp_q = IW'(lim_q);
    end else if (x < -lim_q) begin
      clamp_q = IW'(-lim_q);
    end else begin
      clamp_q = IW'(x);
    end
  endfunction

  // Configuration registers.
  logic                    mode_r;
  logic [LIMIT_W-1:0]      out_lim_r;
  logic [LIMIT_W-1:0]      int_lim_r;
  logic [GAIN_W-1:0]       kp_r, ki_r, kd_r;
  logic [ERR_LIMIT_W-1:0]  err_lim_r, dz_r;

  // Sequencer and datapath registers.
  state_t                  state_r, state_nxt;
  logic                    op_r, op_nxt;
  logic signed [EW-1:0]    err_r, err_nxt;
  logic signed [SW-1:0]    gyro_r, gyro_nxt;
  logic signed [EW-1:0]    prev_err_r, prev_err_nxt;
  logic signed [EW-1:0]    prev2_err_r, prev2_err_nxt;
  logic signed [IW-1:0]    integ_r, integ_nxt;
  logic signed [DW-1:0]    fd_r, fd_nxt;
  logic signed [IW-1:0]    pdo_r, pdo_nxt;
  logic signed [PW-1:0]    prod_r, prod_nxt;
  logic signed [PW-1:0]    p_r, p_nxt;
  logic signed [IW-1:0]    i_r, i_nxt;
  logic signed [PW-1:0]    d_r, d_nxt;
  logic [DIFFW-1:0]        diff_r, diff_nxt;
  logic signed [ACCW-1:0]  acc_r, acc_nxt;
  logic [CNTW-1:0]         cnt_r, cnt_nxt;
  logic [DIVW-1:0]         div_q_r, div_q_nxt;
  logic [6:0]              div_rem_r, div_rem_nxt;
  logic                    div_neg_r, div_neg_nxt;
  logic signed [IW-1:0]    res_r, res_nxt;
  logic                    supp_r, supp_nxt;
  logic                    out_tvalid_r, out_tvalid_nxt;
  logic [DRIVE_W-1:0]      out_drive_r, out_drive_nxt;
  logic                    out_supp_r, out_supp_nxt;

  // Shared multiplier operands.
  logic signed [AW-1:0]    mul_a;
  logic signed [BW-1:0]    mul_b;

  // Combinational helpers.
  logic                    in_accept;
  logic signed [BW-1:0]    err_b, d1_b, d2_b;
  logic [EW-1:0]           err_mag;
  logic                    supp_hit;
  logic                    is_inc, is_gyro;
  logic signed [SUMW-1:0]  itmp;
  logic signed [DW-1:0]    dnew;
  logic [CW-1:0]           chunk;
  logic signed [ACCW-1:0]  filt_sum, filt_adj;
  logic [PW-1:0]           prod_mag;
  logic [7:0]              dv_rem;
  logic [DIVW-1:0]         dv_q;
  logic signed [PW-1:0]    div_quot;
  logic signed [SUMW-1:0]  sum_base, sum_d, sum_all;
  logic signed [IW-1:0]    sum_clamped, res_adj;

  assign is_inc  = (mode_r == MODE_INCREMENTAL);
  assign is_gyro = (op_r == OP_GYRO);
  assign in_tready = (state_r == S_IDLE);
  assign in_accept = in_tvalid && in_tready;

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_drive_r;
  assign out_tuser  = out_supp_r;

  // Error differences in multiplier operand width.
  assign err_b = BW'(err_r);
  assign d1_b  = err_b - BW'(prev_err_r);
  assign d2_b  = err_b - (BW'(prev_err_r) <<< 1) + BW'(prev2_err_r);
  assign err_mag = err_r[EW-1] ? EW'(-err_r) : EW'(err_r);
  assign supp_hit = (op_r == OP_NORMAL) &&
                    (((err_lim_r != '0) && (CMPW'(err_mag) > CMPW'(err_lim_r))) ||
                     ((dz_r != '0) && (CMPW'(err_mag) < CMPW'(dz_r))));

  // Operand selection for the shared multiplier.
  assign chunk = diff_r[DIFFW-1 -: CW];
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_MUL_P: begin
        mul_a = AW'(kp_r);
        mul_b = is_inc ? d1_b : err_b;
      end
      S_MUL_I: begin
        mul_a = AW'(ki_r);
        mul_b = err_b;
      end
      S_MUL_D: begin
        mul_a = AW'(kd_r);
        if (is_inc) begin
          mul_b = d2_b;
        end else if (is_gyro) begin
          mul_b = BW'(gyro_r);
        end else begin
          mul_b = d1_b;
        end
      end
      S_LPF: begin
        mul_a = AW'(LPF_NEW);
        mul_b = (cnt_r == '0) ? {chunk[CW-1], chunk} : {1'b0, chunk};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign prod_nxt = PW'(mul_a) * PW'(mul_b);

  // Integral update, filter arithmetic and divide step.
  assign itmp = (!is_inc && is_gyro && (ki_r < GAIN_W'(KI_MIN))) ? '0 :
                is_inc ? SUMW'(prod_r) : SUMW'(integ_r) + SUMW'(prod_r);
  assign dnew = DW'(prod_r);
  assign filt_sum = acc_r + (ACCW'(fd_r) <<< F);
  assign filt_adj = filt_sum +
                    (filt_sum[ACCW-1] ? $signed({{(ACCW-F){1'b0}}, {F{1'b1}}}) : '0);
  assign prod_mag = prod_r[PW-1] ? PW'(-prod_r) : PW'(prod_r);
  assign div_quot = PW'(div_q_r);

  always_comb begin
    dv_rem = {1'b0, div_rem_r};
    dv_q   = div_q_r;
    for (int k = 0; k < 4; k++) begin
      dv_rem = {dv_rem[6:0], dv_q[DIVW-1]};
      dv_q   = dv_q << 1;
      if (dv_rem >= GYRO_DIV) begin
        dv_rem = dv_rem - GYRO_DIV;
        dv_q[0] = 1'b1;
      end
    end
  end

  // Final sum of the terms and toward-zero conversion to an integer.
  assign sum_base = is_inc ? SUMW'(pdo_r) : '0;
  assign sum_d    = is_inc ? SUMW'(prod_r) : SUMW'(d_r);
  assign sum_all  = sum_base + SUMW'(p_r) + SUMW'(i_r) + sum_d;
  assign sum_clamped = clamp_q(sum_all, out_lim_r);
  assign res_adj = res_r + (res_r[IW-1] ? $signed({{(IW-F){1'b0}}, {F{1'b1}}}) : '0);

  // Sequencer next state.
  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    err_nxt        = err_r;
    gyro_nxt       = gyro_r;
    prev_err_nxt   = prev_err_r;
    prev2_err_nxt  = prev2_err_r;
    integ_nxt      = integ_r;
    fd_nxt         = fd_r;
    pdo_nxt        = pdo_r;
    p_nxt          = p_r;
    i_nxt          = i_r;
    d_nxt          = d_r;
    diff_nxt       = diff_r;
    acc_nxt        = acc_r;
    cnt_nxt        = cnt_r;
    div_q_nxt      = div_q_r;
    div_rem_nxt    = div_rem_r;
    div_neg_nxt    = div_neg_r;
    res_nxt        = res_r;
    supp_nxt       = supp_r;
    out_drive_nxt  = out_drive_r;
    out_supp_nxt   = out_supp_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;

    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          op_nxt    = in_tuser;
          err_nxt   = EW'($signed(in_tdata[2*SW-1 -: SW])) -
                      EW'($signed(in_tdata[SW-1:0]));
          gyro_nxt  = $signed(in_tdata[3*SW-1 -: SW]);
          state_nxt = S_CHECK;
        end
      end
      // Error limit and dead zone; incremental gyro reuses the held output.
      S_CHECK: begin
        supp_nxt = supp_hit;
        if (supp_hit) begin
          res_nxt   = '0;
          state_nxt = S_OUT;
        end else if (is_inc && is_gyro) begin
          state_nxt = S_SUM;
        end else begin
          state_nxt = S_MUL_P;
        end
      end
      S_MUL_P: begin
        state_nxt = S_MUL_I;
      end
      S_MUL_I: begin
        p_nxt     = prod_r;
        state_nxt = S_MUL_D;
      end
      // Integral product is ready: clamp it and pick the derivative path.
      S_MUL_D: begin
        i_nxt = clamp_q(itmp, int_lim_r);
        if (is_inc) begin
          state_nxt = S_SUM;
        end else begin
          integ_nxt = clamp_q(itmp, int_lim_r);
          state_nxt = is_gyro ? S_DIV_LOAD : S_DIFF;
        end
      end
      // Filter: fd*ONE + (dnew - fd)*LPF_NEW, chunk by chunk from the top.
      S_DIFF: begin
        diff_nxt  = DIFFW'(DIFFW'(dnew) - DIFFW'(fd_r));
        acc_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = S_LPF;
      end
      S_LPF: begin
        diff_nxt = diff_r << CW;
        if (cnt_r != '0) begin
          acc_nxt = (acc_r <<< CW) + ACCW'(prod_r);
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNTW'(NCHUNK)) begin
          state_nxt = S_FILT;
        end
      end
      S_FILT: begin
        fd_nxt    = DW'(filt_adj >>> F);
        d_nxt     = PW'(DW'(filt_adj >>> F));
        state_nxt = S_SUM;
      end
      // Gyro derivative: -(kd * gyro) / 100, truncated toward zero.
      S_DIV_LOAD: begin
        div_neg_nxt = prod_r[PW-1];
        div_q_nxt   = DIVW'(prod_mag);
        div_rem_nxt = '0;
        cnt_nxt     = '0;
        state_nxt   = S_DIV;
      end
      S_DIV: begin
        div_q_nxt   = dv_q;
        div_rem_nxt = dv_rem[6:0];
        cnt_nxt     = cnt_r + 1'b1;
        if (cnt_r == CNTW'(DIV_STEPS - 1)) begin
          state_nxt = S_DIV_END;
        end
      end
      S_DIV_END: begin
        d_nxt     = div_neg_r ? div_quot : -div_quot;
        state_nxt = S_SUM;
      end
      // Sum, clamp, hold the incremental output and advance the history.
      S_SUM: begin
        if (is_inc && is_gyro) begin
          res_nxt = pdo_r;
        end else begin
          res_nxt = sum_clamped;
          if (is_inc) begin
            pdo_nxt = sum_clamped;
          end
        end
        prev2_err_nxt = prev_err_r;
        prev_err_nxt  = err_r;
        state_nxt     = S_OUT;
      end
      // Hand the result to the output register once it is free.
      S_OUT: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_drive_nxt  = DRIVE_W'(res_adj >>> F);
          out_supp_nxt   = supp_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Sequencer state, controller state and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
      prev_err_r   <= '0;
      prev2_err_r  <= '0;
      integ_r      <= '0;
      fd_r         <= '0;
      pdo_r        <= '0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      prev_err_r   <= prev_err_nxt;
      prev2_err_r  <= prev2_err_nxt;
      integ_r      <= integ_nxt;
      fd_r         <= fd_nxt;
      pdo_r        <= pdo_nxt;
    end
    op_r        <= op_nxt;
    err_r       <= err_nxt;
    gyro_r      <= gyro_nxt;
    prod_r      <= prod_nxt;
    p_r         <= p_nxt;
    i_r         <= i_nxt;
    d_r         <= d_nxt;
    diff_r      <= diff_nxt;
    acc_r       <= acc_nxt;
    cnt_r       <= cnt_nxt;
    div_q_r     <= div_q_nxt;
    div_rem_r   <= div_rem_nxt;
    div_neg_r   <= div_neg_nxt;
    res_r       <= res_nxt;
    supp_r      <= supp_nxt;
    out_drive_r <= out_drive_nxt;
    out_supp_r  <= out_supp_nxt;
  end

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_POSITIONAL;
      out_lim_r <= '1;
      int_lim_r <= '1;
      kp_r      <= '0;
      ki_r      <= '0;
      kd_r      <= '0;
      err_lim_r <= '0;
      dz_r      <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_CONTROL_MODE:   mode_r    <= cfg_data[0];
        REG_OUTPUT_LIMIT:   out_lim_r <= cfg_data[LIMIT_W-1:0];
        REG_INTEGRAL_LIMIT: int_lim_r <= cfg_data[LIMIT_W-1:0];
        REG_GAIN_P:         kp_r      <= cfg_data[GAIN_W-1:0];
        REG_GAIN_I:         ki_r      <= cfg_data[GAIN_W-1:0];
        REG_GAIN_D:         kd_r      <= cfg_data[GAIN_W-1:0];
        REG_ERROR_LIMIT:    err_lim_r <= cfg_data[ERR_LIMIT_W-1:0];
        REG_DEAD_ZONE:      dz_r      <= cfg_data[ERR_LIMIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- src/ppdc_checker.sv -----
// ----------------------------------------------------------------------------
// ppdc_checker: port-level checks of the PID position/delta controller
// Watches the top-level ports only and is attached by a bind statement.
// ----------------------------------------------------------------------------
module ppdc_checker #(
  parameter int SAMPLE_WIDTH = 16
) (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 cfg_wr_en,
  input logic [ppdc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input logic [ppdc_pkg::CFG_DATA_W-1:0]      cfg_data,
  input logic                                 in_tvalid,
  input logic                                 in_tready,
  // tdata: measured, target, gyro_rate.
  input logic [((3*SAMPLE_WIDTH+7)/8)*8-1:0]  in_tdata,
  // tuser: operation.
  input logic                                 in_tuser,
  input logic                                 out_tvalid,
  input logic                                 out_tready,
  // tdata: drive.
  input logic [ppdc_pkg::DRIVE_W-1:0]         out_tdata,
  // tuser: suppressed.
  input logic                                 out_tuser
);
  import ppdc_pkg::*;

  // The output channel is empty right after reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("out_tvalid high after reset");

  // Only one item is in work: the input closes after an accept.
  a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while an item is in work");

  // A suppressed item always carries a zero drive.
  a_supp_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("suppressed item with nonzero drive");

  // The drive never reaches the most negative code after clamping.
  a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata != {1'b1, {(DRIVE_W-1){1'b0}}})
    else $error("drive outside the clamp range");

  // A stalled result item holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result item changed while stalled");

endmodule

bind pid_position_delta_controller_core ppdc_checker #(
  .SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_ppdc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .cfg_wr_en  (cfg_wr_en),
  .cfg_index  (cfg_index),
  .cfg_data   (cfg_data),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: testbench of the positional / incremental PID controller core
// Drives measurement items into the stream input and predicts each drive value
// with a bit-exact fixed-point model of the controller. Register settings change
// only while the core is idle. Both stream sides stall at random, and the
// result side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ppdc_pkg::*;

  localparam int     SAMPLE_W      = 16;
  localparam int     FRAC          = 16;
  localparam longint ONE_Q         = longint'(1) << FRAC;
  localparam longint LPF_NEW       = ((longint'(3) << FRAC) + 2) / 5;
  localparam longint KI_MIN        = ((longint'(1) << FRAC) + 999) / 1000;
  localparam int     SETTLE_CYCLES = 40;
  localparam int     CYCLE_LIMIT   = 400000;
  localparam int     RANDOM_PHASES = 12;
  localparam int     PHASE_ITEMS   = 75;

  typedef struct packed {
    logic [DRIVE_W-1:0] drive;
    logic               suppressed;
  } drive_result_t;

  // Clock, reset and block ports.
  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  cfg_wr_en  = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  // tdata: measured [15:0], target [31:16], gyro_rate [47:32].
  logic [47:0]           in_tdata   = '0;
  // tuser: operation.
  logic                  in_tuser   = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // tdata: drive [15:0].
  logic [DRIVE_W-1:0]    out_tdata;
  // tuser: suppressed.
  logic                  out_tuser;

  // Controller copy: registers and state after reset.
  logic   ctl_mode      = MODE_POSITIONAL;
  longint out_lim       = 32767;
  longint int_lim       = 32767;
  longint kp_gain       = 0;
  longint ki_gain       = 0;
  longint kd_gain       = 0;
  longint err_lim       = 0;
  longint dead_band     = 0;
  longint last_err      = 0;
  longint older_err     = 0;
  longint integ_acc     = 0;
  longint deriv_filt    = 0;
  longint held_drive    = 0;

  drive_result_t expected_drives[$];
  int  fail_count      = 0;
  int  items_sent      = 0;
  int  results_checked = 0;
  int  settings_count  = 0;
  bit  idle_en         = 1'b1;
  int  hold_request    = 0;
  bit  sink_holding    = 1'b0;

  pid_position_delta_controller_core #(
    .SAMPLE_WIDTH  (SAMPLE_W),
    .FRACTION_BITS (FRAC)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Symmetric clamp of a Q16 value to an integer limit.
  function automatic longint clamp_q(longint x, longint lim);
    longint bound;
    bound = lim * ONE_Q;
    if (x > bound) return bound;
    if (x < -bound) return -bound;
    return x;
  endfunction

  // Computes the drive for one item and advances the controller copy.
  function automatic drive_result_t predict_drive(logic op, logic signed [15:0] meas,
                                                  logic signed [15:0] targ,
                                                  logic signed [15:0] gyro);
    drive_result_t r;
    longint err, mag, p_term, i_term, d_term, d_raw, acc;
    err = longint'(targ) - longint'(meas);
    mag = (err < 0) ? -err : err;
    r.suppressed = 1'b0;
    r.drive = '0;
    if (op == OP_NORMAL && ((err_lim != 0 && mag > err_lim) ||
                            (dead_band != 0 && mag < dead_band))) begin
      // The limits only gate the normal operation; no state moves.
      r.suppressed = 1'b1;
    end else begin
      if (ctl_mode == MODE_POSITIONAL) begin
        p_term = kp_gain * err;
        if (op == OP_NORMAL) begin
          d_raw = kd_gain * (err - last_err);
          d_term = (d_raw * LPF_NEW + deriv_filt * (ONE_Q - LPF_NEW)) / ONE_Q;
          integ_acc = integ_acc + ki_gain * err;
          deriv_filt = d_term;
        end else begin
          // A tiny integral gain wipes the integral on the gyro operation.
          if (ki_gain >= KI_MIN) integ_acc = integ_acc + ki_gain * err;
          else integ_acc = 0;
          d_term = -(kd_gain * longint'(gyro)) / longint'(GYRO_DIV);
        end
        integ_acc = clamp_q(integ_acc, int_lim);
        acc = clamp_q(p_term + integ_acc + d_term, out_lim);
      end else if (op == OP_NORMAL) begin
        p_term = kp_gain * (err - last_err);
        i_term = clamp_q(ki_gain * err, int_lim);
        d_term = kd_gain * (err - 2 * last_err + older_err);
        held_drive = clamp_q(held_drive + p_term + i_term + d_term, out_lim);
        acc = held_drive;
      end else begin
        acc = held_drive;
      end
      older_err = last_err;
      last_err = err;
      r.drive = DRIVE_W'(acc / ONE_Q);
    end
    return r;
  endfunction

  // Offers one item, with an optional gap first, and records its prediction.
  task automatic send_item(input logic op, input logic signed [15:0] meas,
                           input logic signed [15:0] targ, input logic signed [15:0] gyro);
    int gap;
    if (idle_en && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 17);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {gyro, targ, meas};
    do @(posedge clk); while (!in_tready);
    expected_drives.push_back(predict_drive(op, meas, targ, gyro));
    items_sent++;
  endtask

  // Lowers valid in the step of the last acceptance of a burst.
  task automatic end_burst();
    in_tvalid <= 1'b0;
  endtask

  // Waits until every result is in and the core has gone quiet.
  task automatic drain();
    while (expected_drives.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      REG_CONTROL_MODE:   ctl_mode  = val[0];
      REG_OUTPUT_LIMIT:   out_lim   = val[LIMIT_W-1:0];
      REG_INTEGRAL_LIMIT: int_lim   = val[LIMIT_W-1:0];
      REG_GAIN_P:         kp_gain   = val[GAIN_W-1:0];
      REG_GAIN_I:         ki_gain   = val[GAIN_W-1:0];
      REG_GAIN_D:         kd_gain   = val[GAIN_W-1:0];
      REG_ERROR_LIMIT:    err_lim   = val[ERR_LIMIT_W-1:0];
      REG_DEAD_ZONE:      dead_band = val[ERR_LIMIT_W-1:0];
      default: ;
    endcase
  endtask

  // Writes every register once the core is idle.
  task automatic set_config(input logic mode, input int olim, input int ilim,
                            input int kp, input int ki, input int kd,
                            input int elim, input int dz);
    drain();
    write_reg(REG_CONTROL_MODE,   CFG_DATA_W'(mode));
    write_reg(REG_OUTPUT_LIMIT,   CFG_DATA_W'(olim));
    write_reg(REG_INTEGRAL_LIMIT, CFG_DATA_W'(ilim));
    write_reg(REG_GAIN_P,         CFG_DATA_W'(kp));
    write_reg(REG_GAIN_I,         CFG_DATA_W'(ki));
    write_reg(REG_GAIN_D,         CFG_DATA_W'(kd));
    write_reg(REG_ERROR_LIMIT,    CFG_DATA_W'(elim));
    write_reg(REG_DEAD_ZONE,      CFG_DATA_W'(dz));
    cfg_wr_en <= 1'b0;
    settings_count++;
  endtask

  function automatic int pick_gain();
    case ($urandom_range(0, 4))
      0:       return 0;
      1:       return $urandom_range(0, 24'hFFFFFF);
      2:       return $urandom_range(0, 32'h40000);
      3:       return $urandom_range(0, 32'h2000);
      default: return $urandom_range(0, 130);
    endcase
  endfunction

  function automatic int pick_limit();
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return 32767;
      2:       return $urandom_range(1, 500);
      default: return $urandom_range(1, 32767);
    endcase
  endfunction

  task automatic random_config();
    logic mode;
    int   elim, dz;
    mode = $urandom_range(0, 1) ? MODE_INCREMENTAL : MODE_POSITIONAL;
    elim = 0;
    dz = 0;
    if ($urandom_range(0, 2) == 0)
      elim = $urandom_range(0, 1) ? $urandom_range(1, 3000) : $urandom_range(1, 65535);
    if ($urandom_range(0, 3) == 0) dz = $urandom_range(1, 300);
    set_config(mode, pick_limit(), pick_limit(), pick_gain(), pick_gain(), pick_gain(),
               elim, dz);
  endtask

  // One random item: mostly small errors, some full-range and extreme samples.
  task automatic send_random_item();
    logic              op;
    logic signed [15:0] meas, targ, gyro;
    op = ($urandom_range(0, 3) == 0) ? OP_GYRO : OP_NORMAL;
    meas = 16'($urandom);
    case ($urandom_range(0, 4))
      0: targ = 16'($urandom);
      1: targ = meas + 16'($urandom_range(0, 64)) - 16'sd32;
      2: targ = meas + 16'($urandom_range(0, 4000)) - 16'sd2000;
      3: targ = meas + 16'($urandom_range(0, 600)) - 16'sd300;
      default: begin
        meas = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
        targ = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      end
    endcase
    if ($urandom_range(0, 7) == 0) gyro = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
    else gyro = 16'($urandom);
    send_item(op, meas, targ, gyro);
  endtask

  // Reset settings: all gains zero, so every drive is zero.
  task automatic test_reset_defaults();
    send_item(OP_NORMAL, 16'sh8000, 16'sh7FFF, 16'sh0000);
    send_item(OP_GYRO,   16'sh7FFF, 16'sh8000, 16'sh8000);
    end_burst();
  endtask

  // Positional mode: saturating gains, the integral wipe threshold, zero integral clamp.
  task automatic test_positional();
    set_config(MODE_POSITIONAL, 32767, 32767, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 0, 0);
    send_item(OP_NORMAL, 16'sh8000, 16'sh7FFF, 16'sh0000);
    send_item(OP_NORMAL, 16'sh7FFF, 16'sh8000, 16'sh0000);
    send_item(OP_GYRO,   16'sh0000, 16'sh0000, 16'sh7FFF);
    send_item(OP_GYRO,   16'sh0000, 16'sh0000, 16'sh8000);
    end_burst();
    set_config(MODE_POSITIONAL, 1000, 0, 32'h10000, KI_MIN - 1, 32'h8000, 0, 0);
    send_item(OP_NORMAL, 16'sd0, 16'sd100, 16'sd0);
    send_item(OP_GYRO,   16'sd0, 16'sd50, 16'sh8000);
    end_burst();
    set_config(MODE_POSITIONAL, 1000, 2000, 32'h10000, KI_MIN, 32'h8000, 0, 0);
    send_item(OP_GYRO,   16'sd0, -16'sd50, 16'sd12345);
    end_burst();
  endtask

  // Error limit and dead zone at their edges, and the gyro operation bypassing them.
  task automatic test_suppression();
    set_config(MODE_POSITIONAL, 32767, 32767, 32'h20000, 32'h100, 32'h4000, 100, 10);
    send_item(OP_NORMAL, 16'sd0, 16'sd100, 16'sd0);
    send_item(OP_NORMAL, 16'sd0, 16'sd101, 16'sd0);
    send_item(OP_NORMAL, 16'sd0, -16'sd101, 16'sd0);
    send_item(OP_NORMAL, 16'sd0, -16'sd10, 16'sd0);
    send_item(OP_NORMAL, 16'sd0, 16'sd9, 16'sd0);
    send_item(OP_GYRO,   16'sd0, 16'sd500, -16'sd777);
    end_burst();
    set_config(MODE_POSITIONAL, 0, 32767, 32'h20000, 32'h100, 32'h4000, 65535, 65535);
    send_item(OP_NORMAL, 16'sh7FFF, 16'sh8000, 16'sd0);
    send_item(OP_NORMAL, 16'sd1234, 16'sd1234, 16'sd0);
    end_burst();
  endtask

  // Incremental mode: the held drive accumulates, gyro returns it unchanged.
  task automatic test_incremental();
    set_config(MODE_INCREMENTAL, 20000, 5000, 32'h18000, 32'h800, 32'h4000, 0, 50);
    send_item(OP_NORMAL, 16'sd0, 16'sd200, 16'sd0);
    send_item(OP_NORMAL, 16'sd0, -16'sd300, 16'sd0);
    send_item(OP_NORMAL, 16'sd0, 16'sd1000, 16'sd0);
    send_item(OP_GYRO,   16'sd0, 16'sd3, 16'sh7FFF);
    send_item(OP_NORMAL, 16'sd0, 16'sd20, 16'sd0);
    end_burst();
  endtask

  // The result side holds off while items keep coming, so the input stalls.
  task automatic test_backpressure();
    idle_en = 1'b0;
    random_config();
    hold_request = 300;
    while (!sink_holding) @(posedge clk);
    repeat (30) send_random_item();
    end_burst();
    idle_en = 1'b1;
  endtask

  // Random settings, each followed by a run of random items; the last phases run flat out.
  task automatic test_random();
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      idle_en = (ph < RANDOM_PHASES - 2);
      random_config();
      repeat (PHASE_ITEMS) send_random_item();
      end_burst();
    end
  endtask

  // Result side: random stall bursts, and one long hold when asked.
  initial begin : result_sink
    int n;
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_request > 0) begin
        n = hold_request;
        hold_request = 0;
        out_tready <= 1'b0;
        sink_holding = 1'b1;
        repeat (n) @(posedge clk);
        sink_holding = 1'b0;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Compares each accepted result with the oldest prediction.
  always @(posedge clk) begin
    drive_result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_drives.size() == 0) begin
        $error("result with none expected: drive %0d suppressed %0b",
               $signed(out_tdata), out_tuser);
        fail_count++;
      end else begin
        exp_r = expected_drives.pop_front();
        results_checked++;
        if (out_tdata !== exp_r.drive) begin
          $error("drive: expected %0d, got %0d", $signed(exp_r.drive), $signed(out_tdata));
          fail_count++;
        end
        if (out_tuser !== exp_r.suppressed) begin
          $error("suppressed: expected %0b, got %0b", exp_r.suppressed, out_tuser);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin : main_sequence
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_positional();
    test_suppression();
    test_incremental();
    test_backpressure();
    test_random();
    drain();
    $display("Sent %0d items through %0d register settings; %0d results checked.",
             items_sent, settings_count, results_checked);
    $display("Covered both modes, both operations, suppression edges and a long stall.");
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
